// ===== rtl/dxt_pkg.sv =====
package dxt_pkg;

  typedef enum logic [1:0] {
    FMT_DXT1 = 2'd0,
    FMT_DXT3 = 2'd1,
    FMT_DXT5 = 2'd2
  } fmt_t;

  typedef enum logic [1:0] {
    REG_FORMAT     = 2'd0,
    REG_BLOCK_COLS = 2'd1,
    REG_BLOCK_ROWS = 2'd2
  } reg_idx_t;

  localparam logic [24:0] W_ZERO    = 25'd0;
  localparam logic [24:0] W_THIRD   = 25'd11184799;
  localparam logic [24:0] W_2THIRD  = 25'd22369598;
  localparam logic [24:0] W_HALF    = 25'd16777216;

  localparam logic [11:0] DIV7_RECIP = 12'd2341;
  localparam logic [11:0] DIV5_RECIP = 12'd3277;

  typedef struct packed {
    fmt_t        fmt;
    logic        three_color;
    logic        alpha_desc;
    logic [2:0]  cols;
    logic [2:0]  rows;
    logic [23:0] rgb0;
    logic [23:0] rgb1;
    logic [31:0] color_indices;
    logic [7:0]  alpha_ref0;
    logic [7:0]  alpha_ref1;
    logic [63:0] alpha_bits;
  } blk_t;

  typedef struct packed {
    logic [23:0] base;
    logic [8:0]  dr;
    logic [8:0]  dg;
    logic [8:0]  db;
    logic [24:0] weight;
    logic        alpha_div;
    logic        div7;
    logic [10:0] alpha_num;
    logic [7:0]  alpha_direct;
    logic [1:0]  col;
    logic [1:0]  row;
    logic        last;
  } pix_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [2:0] clamp_size(input logic [2:0] v);
    logic [2:0] r;
    if (v == 3'd0) begin
      r = 3'd1;
    end else if (v > 3'd4) begin
      r = 3'd4;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [23:0] expand565(input logic [15:0] c);
    return {c[15:11], 3'b000, c[10:5], 2'b00, c[4:0], 3'b000};
  endfunction

endpackage

// ===== rtl/dxt_fifo.sv =====
module dxt_fifo #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  dxt_pkg::blk_t  wr_data,
  input  logic           rd_en,
  output dxt_pkg::blk_t  rd_data,
  output dxt_pkg::q_stat_t stat
);
  import dxt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  blk_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data    = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

// ===== rtl/dxt_fe.sv =====
module dxt_fe (
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [15:0]      in_color0,
  input  logic [15:0]      in_color1,
  input  logic [31:0]      in_color_indices,
  input  logic [7:0]       in_alpha_ref0,
  input  logic [7:0]       in_alpha_ref1,
  input  logic [63:0]      in_alpha_bits,
  input  logic [1:0]       format,
  input  logic [2:0]       block_cols,
  input  logic [2:0]       block_rows,
  input  dxt_pkg::q_stat_t q_stat,
  output logic             q_wr,
  output dxt_pkg::blk_t    q_data
);
  import dxt_pkg::*;

  fmt_t fmt;

  always_comb begin
    if (format == FMT_DXT3) begin
      fmt = FMT_DXT3;
    end else if (format == FMT_DXT5) begin
      fmt = FMT_DXT5;
    end else begin
      fmt = FMT_DXT1;
    end
  end

  assign in_ready = !q_stat.full;
  assign q_wr     = in_valid && in_ready;

  always_comb begin
    q_data.fmt           = fmt;
    q_data.three_color   = (fmt == FMT_DXT1) && !(in_color0 > in_color1);
    q_data.alpha_desc    = in_alpha_ref0 > in_alpha_ref1;
    q_data.cols          = clamp_size(block_cols);
    q_data.rows          = clamp_size(block_rows);
    q_data.rgb0          = expand565(in_color0);
    q_data.rgb1          = expand565(in_color1);
    q_data.color_indices = in_color_indices;
    q_data.alpha_ref0    = in_alpha_ref0;
    q_data.alpha_ref1    = in_alpha_ref1;
    q_data.alpha_bits    = in_alpha_bits;
  end

endmodule

// ===== rtl/dxt_be.sv =====
module dxt_be (
  input  logic             clk,
  input  logic             rst_n,
  input  dxt_pkg::blk_t    head,
  input  dxt_pkg::q_stat_t q_stat,
  output logic             q_rd,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      out_pixel_rgba,
  output logic [1:0]       out_col,
  output logic [1:0]       out_row,
  output logic             out_last
);
  import dxt_pkg::*;

  logic [1:0]  x_r, x_nxt;
  logic [1:0]  y_r, y_nxt;
  logic [3:0]  n_r, n_nxt;
  pix_t        p1_r, p1_nxt;
  logic        p1_vld_r, p1_vld_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_pixel_rgba_r;
  logic [1:0]  out_col_r;
  logic [1:0]  out_row_r;
  logic        out_last_r;

  logic        out_en, p1_en, issue;
  logic        x_end, y_end;
  logic [1:0]  ci;
  logic [8:0]  diff_r, diff_g, diff_b;
  logic [7:0]  color_alpha;
  logic [3:0]  nib;
  logic [3:0]  pos4;
  logic [5:0]  sel_pos;
  logic [2:0]  sel;
  logic [3:0]  k0;
  logic [2:0]  k1;
  logic [10:0] num;

  logic signed [34:0] pr, pg, pb;
  logic [22:0] aprod;
  logic [7:0]  alpha;

  assign out_en = !out_valid_r || out_ready;
  assign p1_en  = !p1_vld_r || out_en;
  assign issue  = !q_stat.empty && p1_en;
  assign x_end  = ({1'b0, x_r} + 3'd1) == head.cols;
  assign y_end  = ({1'b0, y_r} + 3'd1) == head.rows;
  assign q_rd   = issue && x_end && y_end;

  assign ci     = head.color_indices[{n_r, 1'b0} +: 2];
  assign diff_r = {1'b0, head.rgb1[23:16]} - {1'b0, head.rgb0[23:16]};
  assign diff_g = {1'b0, head.rgb1[15:8]} - {1'b0, head.rgb0[15:8]};
  assign diff_b = {1'b0, head.rgb1[7:0]} - {1'b0, head.rgb0[7:0]};

  assign nib     = head.alpha_bits[{y_r, x_r, 2'b00} +: 4];
  assign pos4    = {~y_r, x_r};
  assign sel_pos = {1'b0, pos4, 1'b0} + {2'b00, pos4};
  assign sel     = head.alpha_bits[sel_pos +: 3];
  assign k0      = head.alpha_desc ? (4'd8 - {1'b0, sel}) : (4'd6 - {1'b0, sel});
  assign k1      = sel - 3'd1;
  assign num     = ({8'b0, k0[2:0]} * {3'b0, head.alpha_ref0})
                 + ({8'b0, k1} * {3'b0, head.alpha_ref1})
                 + (head.alpha_desc ? 11'd3 : 11'd2);

  always_comb begin
    if (head.fmt == FMT_DXT1) begin
      color_alpha = (ci == 2'd3 && head.three_color) ? 8'h00 : 8'hFF;
    end else begin
      color_alpha = 8'h00;
    end
  end

  always_comb begin
    p1_nxt        = p1_r;
    p1_nxt.col    = x_r;
    p1_nxt.row    = y_r;
    p1_nxt.last   = x_end && y_end;
    p1_nxt.base   = head.rgb0;
    p1_nxt.dr     = diff_r;
    p1_nxt.dg     = diff_g;
    p1_nxt.db     = diff_b;
    p1_nxt.weight = W_ZERO;
    case (ci)
      2'd0: begin
        p1_nxt.dr = '0;
        p1_nxt.dg = '0;
        p1_nxt.db = '0;
      end
      2'd1: begin
        p1_nxt.base = head.rgb1;
        p1_nxt.dr   = '0;
        p1_nxt.dg   = '0;
        p1_nxt.db   = '0;
      end
      2'd2: begin
        p1_nxt.weight = head.three_color ? W_HALF : W_THIRD;
      end
      2'd3: begin
        if (head.three_color) begin
          p1_nxt.base = '0;
          p1_nxt.dr   = '0;
          p1_nxt.dg   = '0;
          p1_nxt.db   = '0;
        end else begin
          p1_nxt.weight = W_2THIRD;
        end
      end
      default: begin
        p1_nxt.weight = W_ZERO;
      end
    endcase

    p1_nxt.alpha_div    = 1'b0;
    p1_nxt.div7         = head.alpha_desc;
    p1_nxt.alpha_num    = num;
    p1_nxt.alpha_direct = color_alpha;
    case (head.fmt)
      FMT_DXT3: begin
        p1_nxt.alpha_direct = {nib, 4'h0};
      end
      FMT_DXT5: begin
        if (sel == 3'd0) begin
          p1_nxt.alpha_direct = head.alpha_ref0;
        end else if (sel == 3'd1) begin
          p1_nxt.alpha_direct = head.alpha_ref1;
        end else if (!head.alpha_desc && sel == 3'd6) begin
          p1_nxt.alpha_direct = 8'h00;
        end else if (!head.alpha_desc && sel == 3'd7) begin
          p1_nxt.alpha_direct = 8'hFF;
        end else begin
          p1_nxt.alpha_div = 1'b1;
        end
      end
      default: begin
        p1_nxt.alpha_direct = color_alpha;
      end
    endcase
  end

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    n_nxt = n_r;
    if (issue) begin
      if (x_end && y_end) begin
        x_nxt = '0;
        y_nxt = '0;
        n_nxt = '0;
      end else if (x_end) begin
        x_nxt = '0;
        y_nxt = y_r + 2'd1;
        n_nxt = n_r + 4'd1;
      end else begin
        x_nxt = x_r + 2'd1;
        n_nxt = n_r + 4'd1;
      end
    end
  end

  assign p1_vld_nxt    = issue ? 1'b1 : (out_en ? 1'b0 : p1_vld_r);
  assign out_valid_nxt = out_en ? p1_vld_r : out_valid_r;

  assign pr    = $signed({1'b0, p1_r.weight}) * $signed(p1_r.dr);
  assign pg    = $signed({1'b0, p1_r.weight}) * $signed(p1_r.dg);
  assign pb    = $signed({1'b0, p1_r.weight}) * $signed(p1_r.db);
  assign aprod = {12'b0, p1_r.alpha_num} * {11'b0, p1_r.div7 ? DIV7_RECIP : DIV5_RECIP};
  assign alpha = p1_r.alpha_div ? aprod[21:14] : p1_r.alpha_direct;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r         <= '0;
      y_r         <= '0;
      n_r         <= '0;
      p1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      n_r         <= n_nxt;
      p1_vld_r    <= p1_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p1_r <= p1_nxt;
    end
    if (out_en && p1_vld_r) begin
      out_pixel_rgba_r <= {p1_r.base[23:16] + pr[32:25],
                           p1_r.base[15:8] + pg[32:25],
                           p1_r.base[7:0] + pb[32:25],
                           alpha};
      out_col_r        <= p1_r.col;
      out_row_r        <= p1_r.row;
      out_last_r       <= p1_r.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_rgba = out_pixel_rgba_r;
  assign out_col        = out_col_r;
  assign out_row        = out_row_r;
  assign out_last       = out_last_r;

endmodule

// ===== rtl/dxt_texture_block_decoder.sv =====
// The first pixel of a block passes through the block queue, the p1 stage and the output register.
// A block then streams block_rows * block_cols pixels, each size clamped to 1..4, 16 for a full block.
// Pixel output is the limit: one per cycle while out_ready is high, one block at a time.
// A queue of QDEPTH blocks lets input transfers run ahead of the pixel stream.
// Reset is synchronous and active low; it empties the queue and pipeline and
// sets the format to DXT1 with a 4x4 block size.
module dxt_texture_block_decoder #(
  parameter int QDEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_color0,
  input  logic [15:0] in_color1,
  input  logic [31:0] in_color_indices,
  input  logic [7:0]  in_alpha_ref0,
  input  logic [7:0]  in_alpha_ref1,
  input  logic [63:0] in_alpha_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_pixel_rgba,
  output logic [1:0]  out_col,
  output logic [1:0]  out_row,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dxt_pkg::*;

  logic [1:0] format_r, format_nxt;
  logic [2:0] block_cols_r, block_cols_nxt;
  logic [2:0] block_rows_r, block_rows_nxt;
  logic       cfg_wr;

  q_stat_t q_stat;
  logic    q_wr, q_rd;
  blk_t    q_wdata, q_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    format_nxt     = format_r;
    block_cols_nxt = block_cols_r;
    block_rows_nxt = block_rows_r;
    if (cfg_wr) begin
      case (paddr[3:2])
        REG_FORMAT:     format_nxt     = pwdata[1:0];
        REG_BLOCK_COLS: block_cols_nxt = pwdata[2:0];
        REG_BLOCK_ROWS: block_rows_nxt = pwdata[2:0];
        default: begin
          format_nxt = format_r;
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FORMAT:     prdata = {30'b0, format_r};
      REG_BLOCK_COLS: prdata = {29'b0, block_cols_r};
      REG_BLOCK_ROWS: prdata = {29'b0, block_rows_r};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_r     <= FMT_DXT1;
      block_cols_r <= 3'd4;
      block_rows_r <= 3'd4;
    end else begin
      format_r     <= format_nxt;
      block_cols_r <= block_cols_nxt;
      block_rows_r <= block_rows_nxt;
    end
  end

  dxt_fe u_fe (
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_color0        (in_color0),
    .in_color1        (in_color1),
    .in_color_indices (in_color_indices),
    .in_alpha_ref0    (in_alpha_ref0),
    .in_alpha_ref1    (in_alpha_ref1),
    .in_alpha_bits    (in_alpha_bits),
    .format           (format_r),
    .block_cols       (block_cols_r),
    .block_rows       (block_rows_r),
    .q_stat           (q_stat),
    .q_wr             (q_wr),
    .q_data           (q_wdata)
  );

  dxt_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .stat    (q_stat)
  );

  dxt_be u_be (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_rdata),
    .q_stat         (q_stat),
    .q_rd           (q_rd),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_rgba (out_pixel_rgba),
    .out_col        (out_col),
    .out_row        (out_row),
    .out_last       (out_last)
  );

endmodule

// ===== rtl/dxt_chk.sv =====
module dxt_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pixel_rgba,
  input logic [1:0]  out_col,
  input logic [1:0]  out_row,
  input logic        out_last,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);
  import dxt_pkg::*;

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("Reset did not leave the block empty and ready.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_rgba) &&
      $stable(out_col) && $stable(out_row) && $stable(out_last))
    else $error("A stalled pixel transfer changed.");

  a_pready: assert property (@(posedge clk) pready)
    else $error("The configuration port inserted a wait state.");

  a_format_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pready && paddr[3:2] == REG_FORMAT |=>
      paddr[3:2] != REG_FORMAT || prdata[1:0] == $past(pwdata[1:0]))
    else $error("The format register did not read back the written value.");

endmodule

bind dxt_texture_block_decoder dxt_chk u_chk (.*);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import dxt_pkg::*;

  localparam logic [1:0] FMT_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;
  localparam int BLOCK_TARGET = 500;

  typedef struct packed {
    logic [15:0] c0;
    logic [15:0] c1;
    logic [31:0] idx;
    logic [7:0]  a0;
    logic [7:0]  a1;
    logic [63:0] abits;
  } block_word_t;

  typedef struct packed {
    logic [31:0] rgba;
    logic [1:0]  col;
    logic [1:0]  row;
    logic        last;
  } texel_t;

  class texel_board;
    logic [1:0]  fmt_reg;
    logic [2:0]  cols_reg;
    logic [2:0]  rows_reg;
    texel_t      texels_due[$];
    int          errors;
    int          blocks;
    int          texels;

    function new();
      fmt_reg  = FMT_DXT1;
      cols_reg = 3'd4;
      rows_reg = 3'd4;
      errors   = 0;
      blocks   = 0;
      texels   = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] val);
      case (idx)
        REG_FORMAT:     fmt_reg  = val[1:0];
        REG_BLOCK_COLS: cols_reg = val[2:0];
        REG_BLOCK_ROWS: rows_reg = val[2:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] widen565(logic [15:0] c, logic [7:0] a);
      return {c[15:11], 3'b000, c[10:5], 2'b00, c[4:0], 3'b000, a};
    endfunction

    function logic [31:0] blend(logic [24:0] w, logic [31:0] p0, logic [31:0] p1);
      logic [63:0] wa;
      logic [63:0] wb;
      logic [63:0] v;
      logic [31:0] res;
      wa = 64'd33554432 - {39'd0, w};
      wb = {39'd0, w};
      for (int k = 0; k < 4; k++) begin
        v = (wa * {56'd0, p0[8*k +: 8]} + wb * {56'd0, p1[8*k +: 8]}) >> 25;
        res[8*k +: 8] = v[7:0];
      end
      return res;
    endfunction

    function logic [2:0] fit_size(logic [2:0] v);
      if (v == 3'd0) begin
        return 3'd1;
      end
      if (v > 3'd4) begin
        return 3'd4;
      end
      return v;
    endfunction

    // Predicts the pixels of one block and queues them in emission order.
    function void take_block(block_word_t b);
      logic [31:0] pal[4];
      int          alv[8];
      logic [2:0]  ncols;
      logic [2:0]  nrows;
      logic [31:0] idx;
      logic [31:0] px;
      logic [3:0]  nib;
      logic [2:0]  sel;
      texel_t      t;
      ncols = fit_size(cols_reg);
      nrows = fit_size(rows_reg);
      if (fmt_reg == FMT_DXT3 || fmt_reg == FMT_DXT5) begin
        pal[0] = widen565(b.c0, 8'h00);
        pal[1] = widen565(b.c1, 8'h00);
        pal[2] = blend(W_THIRD, pal[0], pal[1]);
        pal[3] = blend(W_2THIRD, pal[0], pal[1]);
      end else begin
        pal[0] = widen565(b.c0, 8'hFF);
        pal[1] = widen565(b.c1, 8'hFF);
        if (b.c0 > b.c1) begin
          pal[2] = blend(W_THIRD, pal[0], pal[1]);
          pal[3] = blend(W_2THIRD, pal[0], pal[1]);
        end else begin
          pal[2] = blend(W_HALF, pal[0], pal[1]);
          pal[3] = 32'd0;
        end
      end
      alv[0] = b.a0;
      alv[1] = b.a1;
      if (b.a0 > b.a1) begin
        for (int i = 2; i < 8; i++) begin
          alv[i] = ((8 - i) * b.a0 + (i - 1) * b.a1 + 3) / 7;
        end
      end else begin
        for (int i = 2; i < 6; i++) begin
          alv[i] = ((6 - i) * b.a0 + (i - 1) * b.a1 + 2) / 5;
        end
        alv[6] = 0;
        alv[7] = 255;
      end
      idx = b.idx;
      for (int y = 0; y < nrows; y++) begin
        for (int x = 0; x < ncols; x++) begin
          px = pal[idx[1:0]];
          idx = idx >> 2;
          if (fmt_reg == FMT_DXT3) begin
            nib = 4'(b.abits >> (16 * y + 4 * x));
            px = px | {24'd0, nib, 4'd0};
          end else if (fmt_reg == FMT_DXT5) begin
            sel = 3'(b.abits >> (3 * (4 * (3 - y) + x)));
            px = px | (alv[sel] & 32'hFF);
          end
          t.rgba = px;
          t.col  = 2'(x);
          t.row  = 2'(y);
          t.last = (y == nrows - 1) && (x == ncols - 1);
          texels_due.push_back(t);
        end
      end
      blocks++;
    endfunction

    function void check_texel(texel_t got);
      texel_t want;
      if (texels_due.size() == 0) begin
        $display("%0t: unexpected pixel rgba=%h col=%0d row=%0d last=%0b",
                 $time, got.rgba, got.col, got.row, got.last);
        errors++;
        return;
      end
      want = texels_due.pop_front();
      texels++;
      if (got.rgba !== want.rgba) begin
        $display("%0t: rgba expected %h actual %h", $time, want.rgba, got.rgba);
        errors++;
      end
      if (got.col !== want.col) begin
        $display("%0t: col expected %0d actual %0d", $time, want.col, got.col);
        errors++;
      end
      if (got.row !== want.row) begin
        $display("%0t: row expected %0d actual %0d", $time, want.row, got.row);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_color0 = '0;
  logic [15:0] in_color1 = '0;
  logic [31:0] in_color_indices = '0;
  logic [7:0]  in_alpha_ref0 = '0;
  logic [7:0]  in_alpha_ref1 = '0;
  logic [63:0] in_alpha_bits = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_pixel_rgba;
  logic [1:0]  out_col;
  logic [1:0]  out_row;
  logic        out_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  texel_board  sb;
  logic        tx_steady = 1'b0;
  logic        rx_steady = 1'b0;
  logic        hold_pending = 1'b0;
  int          settings_used = 0;

  always #4 clk = ~clk;

  dxt_texture_block_decoder u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_color0        (in_color0),
    .in_color1        (in_color1),
    .in_color_indices (in_color_indices),
    .in_alpha_ref0    (in_alpha_ref0),
    .in_alpha_ref1    (in_alpha_ref1),
    .in_alpha_bits    (in_alpha_bits),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_rgba   (out_pixel_rgba),
    .out_col          (out_col),
    .out_row          (out_row),
    .out_last         (out_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.take_block({in_color0, in_color1, in_color_indices,
                       in_alpha_ref0, in_alpha_ref1, in_alpha_bits});
      end
      if (out_valid && out_ready) begin
        sb.check_texel({out_pixel_rgba, out_col, out_row, out_last});
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable) || !rst_n) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin : pixel_sink
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        stall = HOLD_CYCLES;
      end else if (rx_steady) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 16);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.texels_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(input logic [1:0] fmt, input logic [2:0] cols,
                           input logic [2:0] rows);
    drain();
    reg_write(REG_FORMAT, {30'd0, fmt});
    reg_write(REG_BLOCK_COLS, {29'd0, cols});
    reg_write(REG_BLOCK_ROWS, {29'd0, rows});
    settings_used++;
  endtask

  // Must be called right after a rising edge; returns at the edge of the transfer.
  task automatic send_block(input block_word_t b);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_color0        <= b.c0;
    in_color1        <= b.c1;
    in_color_indices <= b.idx;
    in_alpha_ref0    <= b.a0;
    in_alpha_ref1    <= b.a1;
    in_alpha_bits    <= b.abits;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic block_word_t random_block();
    block_word_t b;
    b.c0    = 16'($urandom);
    b.c1    = ($urandom_range(0, 9) == 0) ? b.c0 : 16'($urandom);
    b.idx   = $urandom;
    b.a0    = 8'($urandom);
    b.a1    = ($urandom_range(0, 9) == 0) ? b.a0 : 8'($urandom);
    b.abits = {$urandom, $urandom};
    return b;
  endfunction

  initial begin : stimulus
    logic [1:0] fmt;
    logic [2:0] cols;
    logic [2:0] rows;
    int         phase;
    int         count;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: DXT1 with a 4x4 block, both palette modes.
    send_block({16'hFFFF, 16'h0000, 32'hE4E4E4E4, 8'hFF, 8'hFF, 64'hFFFFFFFFFFFFFFFF});
    send_block({16'h0000, 16'hFFFF, 32'hE4E4E4E4, 8'h00, 8'h00, 64'h0});
    send_block({16'h1234, 16'h1234, 32'hFFFFFFFF, 8'h55, 8'hAA, 64'h5555AAAA5555AAAA});
    send_block({16'hF81F, 16'h07E0, 32'h1B1B1B1B, 8'hFF, 8'h00, 64'hFFFFFFFFFFFFFFFF});

    configure(FMT_DXT3, 3'd4, 3'd4);
    send_block({16'h0000, 16'hFFFF, 32'hE4E4E4E4, 8'h00, 8'h00, 64'h0123456789ABCDEF});
    send_block({16'hFFFF, 16'h0000, 32'h1B1B1B1B, 8'hFF, 8'hFF, 64'hFFFFFFFFFFFFFFFF});
    send_block({16'h8410, 16'h8410, 32'h00000000, 8'h00, 8'h00, 64'h0});

    configure(FMT_DXT5, 3'd4, 3'd4);
    send_block({16'hFFFF, 16'h0000, 32'hE4E4E4E4, 8'd200, 8'd10, 64'hFFFFFAC688FAC688});
    send_block({16'h0000, 16'hFFFF, 32'hE4E4E4E4, 8'd10, 8'd200, 64'hFFFFFAC688FAC688});
    send_block({16'h7BEF, 16'h7BEF, 32'h1B1B1B1B, 8'd77, 8'd77, 64'h0000FAC688FAC688});
    send_block({16'hF800, 16'h001F, 32'hFFFFFFFF, 8'd255, 8'd0, 64'h0000FFFFFFFFFFFF});
    send_block({16'h07E0, 16'hF800, 32'h00000000, 8'd0, 8'd255, 64'hFFFF000000000000});

    // Unused format code, and sizes below and above the legal range.
    configure(FMT_UNUSED, 3'd0, 3'd7);
    send_block({16'hFFFF, 16'h0000, 32'hE4E4E4E4, 8'h00, 8'h00, 64'h0});
    send_block({16'h0000, 16'hFFFF, 32'hFFFFFFFF, 8'h00, 8'h00, 64'h0});
    configure(FMT_DXT1, 3'd7, 3'd0);
    send_block({16'h0001, 16'hFFFE, 32'h39393939, 8'h00, 8'h00, 64'h0});

    configure(FMT_DXT5, 3'd3, 3'd2);
    send_block({16'hFFFF, 16'h0000, 32'hE4E4E4E4, 8'd200, 8'd10, 64'hFFFFFAC688FAC688});
    send_block({16'h1234, 16'hABCD, 32'h9C9C9C9C, 8'd10, 8'd200, 64'h0000FAC688FAC688});
    configure(FMT_DXT3, 3'd1, 3'd1);
    send_block({16'hFFFF, 16'h0000, 32'h00000003, 8'h00, 8'h00, 64'h000000000000000F});
    send_block({16'h0000, 16'hFFFF, 32'h00000002, 8'h00, 8'h00, 64'h0000000000000007});
    configure(FMT_DXT1, 3'd2, 3'd4);
    send_block({16'h0000, 16'hFFFF, 32'hFFFFFFFF, 8'h00, 8'h00, 64'h0});

    phase = 0;
    while (sb.blocks < BLOCK_TARGET) begin
      case ($urandom_range(0, 6))
        0, 1:    fmt = FMT_DXT1;
        2, 3:    fmt = FMT_DXT3;
        4, 5:    fmt = FMT_DXT5;
        default: fmt = FMT_UNUSED;
      endcase
      cols = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
      rows = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
      configure(fmt, cols, rows);
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      if (phase == 2) begin
        tx_steady = 1'b1;
        rx_steady = 1'b0;
        hold_pending = 1'b1;
      end
      count = $urandom_range(20, 60);
      repeat (count) send_block(random_block());
      phase++;
    end

    drain();
    repeat (16) @(posedge clk);
    $display("tb: %0d blocks decoded into %0d checked pixels", sb.blocks, sb.texels);
    $display("tb: %0d register settings, all formats and out-of-range sizes included",
             settings_used);
    if (sb.errors == 0 && sb.texels_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dxt_pkg.sv
rtl/dxt_fifo.sv
rtl/dxt_fe.sv
rtl/dxt_be.sv
rtl/dxt_texture_block_decoder.sv
rtl/dxt_chk.sv
tb/sv/tb_top.sv
